FILE: rtl/spwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment prefetch weight table package
// Widths, register codes and shared types for the weight table.
// ----------------------------------------------------------------------------
package spwt_pkg;

    localparam int SEGMENTS = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = $clog2(SEGMENTS + 1);
    localparam int W_W      = 16;
    localparam int MAXP_W   = 10;
    localparam int RATE_W   = 8;
    localparam int SCNT_W   = 7;
    localparam int PROD_W   = IDX_W + RATE_W;
    localparam int SUM_W    = W_W + 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_MAX_PRIO  = 2'd0;
    localparam logic [1:0] REG_DECAY     = 2'd1;
    localparam logic [1:0] REG_SEG_COUNT = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]  cur;
        logic [IDX_W-1:0]  idx;
        logic [MAXP_W-1:0] max_prio;
        logic [RATE_W-1:0] rate;
    } t_upd_ctrl;

endpackage

FILE: rtl/spwt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment prefetch weight table channels
// Valid/ready interfaces for segment events and weight results.
// ----------------------------------------------------------------------------
interface spwt_in_if;
    import spwt_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] current_segment;

    modport source (output valid, output current_segment, input ready);
    modport sink   (input valid, input current_segment, output ready);
endinterface

interface spwt_out_if;
    import spwt_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] segment_index;
    logic [W_W-1:0]   weight;
    logic             wanted;
    logic             last;

    modport source (output valid, output segment_index, output weight, output wanted,
                    output last, input ready);
    modport sink   (input valid, input segment_index, input weight, input wanted,
                    input last, output ready);
endinterface

FILE: rtl/spwt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight cell
// One stored weight of the ring; takes its neighbor's value on a shift.
// ----------------------------------------------------------------------------
module spwt_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic [spwt_pkg::W_W-1:0] i_d,
    output logic [spwt_pkg::W_W-1:0] o_q
);
    import spwt_pkg::*;

    logic [W_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/spwt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight update unit
// Computes the new weight of the segment at the head of the ring.
// ----------------------------------------------------------------------------
module spwt_update (
    input  spwt_pkg::t_upd_ctrl      i_ctrl,
    input  logic [spwt_pkg::W_W-1:0] i_w,
    output logic [spwt_pkg::W_W-1:0] o_w
);
    import spwt_pkg::*;

    logic [IDX_W-1:0]  gap;
    logic [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        if (i_ctrl.idx > i_ctrl.cur) begin
            gap = i_ctrl.idx - i_ctrl.cur;
        end else begin
            gap = i_ctrl.cur - i_ctrl.idx;
        end
        prod = PROD_W'(gap) * PROD_W'(i_ctrl.rate);

        if (i_ctrl.idx == i_ctrl.cur) begin
            sum = $signed(SUM_W'(i_ctrl.max_prio));
        end else if (i_ctrl.idx < i_ctrl.cur) begin
            sum = $signed(SUM_W'(i_w)) - $signed(SUM_W'(prod));
        end else if (prod > PROD_W'({i_ctrl.max_prio, 1'b0})) begin
            // Forward gain bottoms out at minus the maximum priority.
            sum = $signed(SUM_W'(i_w)) - $signed(SUM_W'(i_ctrl.max_prio));
        end else begin
            sum = $signed(SUM_W'(i_w)) + $signed(SUM_W'(i_ctrl.max_prio))
                - $signed(SUM_W'(prod));
        end

        if (sum[SUM_W-1]) begin
            o_w = '0;
        end else if (sum[SUM_W-2:W_W] != '0) begin
            o_w = '1;
        end else begin
            o_w = sum[W_W-1:0];
        end
    end

endmodule

FILE: rtl/segment_prefetch_weight_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment prefetch weight table
// Keeps one priority weight per segment and rewrites them on each event.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per segment change: the index of the segment
//   now playing. o_out carries one transaction per segment in use, in index
//   order, with its new weight, the wanted flag and last on the final one.
//   Registers (max priority, decay rate, segment count) are to be written over
//   the APB-style port while the block is idle; the block does not enforce it.
//   The weights sit in a ring of SEGMENTS cells that rotates one place per
//   cycle, except while a stall holds it, through a single update unit at its
//   head. Each result is registered in the output register as its segment
//   passes the head, one per cycle while the receiver keeps up. i_in.ready is
//   high again once the ring is back in place after a full turn of rotation.
//   Segments beyond the count pass the update unit unchanged and are not sent.
//   When the receiver stalls, the ring halts whenever it would need to
//   present a new result, so nothing is lost.
//   Reset clears all weights to zero at once and loads the register defaults.
// ----------------------------------------------------------------------------
module segment_prefetch_weight_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spwt_in_if.sink                     i_in,
    spwt_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spwt_pkg::ADDR_W-1:0] paddr,
    input  logic [spwt_pkg::DATA_W-1:0] pwdata,
    output logic [spwt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import spwt_pkg::*;

    logic [MAXP_W-1:0] r_max_prio;
    logic [RATE_W-1:0] r_rate;
    logic [SCNT_W-1:0] r_seg_count;
    logic              r_busy;
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_cur;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [W_W-1:0]    r_out_weight;
    logic              r_out_wanted;
    logic              r_out_last;

    logic [CNT_W-1:0]  count_eff;
    logic              emit;
    logic              step;
    logic              is_last;
    logic              wr_en;
    logic [W_W-1:0]    new_w;
    logic [W_W-1:0]    ring_in;
    logic [W_W-1:0]    cell_q [SEGMENTS];
    t_upd_ctrl         ctrl;

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_prio  <= MAXP_W'(10);
            r_rate      <= RATE_W'(3);
            r_seg_count <= SCNT_W'(SEGMENTS);
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MAX_PRIO:  r_max_prio  <= pwdata[MAXP_W-1:0];
                REG_DECAY:     r_rate      <= pwdata[RATE_W-1:0];
                REG_SEG_COUNT: r_seg_count <= pwdata[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_PRIO:  prdata = DATA_W'(r_max_prio);
            REG_DECAY:     prdata = DATA_W'(r_rate);
            REG_SEG_COUNT: prdata = DATA_W'(r_seg_count);
            default:       prdata = '0;
        endcase
    end

    // A count of zero acts as one; anything above the table size is clipped.
    always_comb begin
        if (r_seg_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (r_seg_count > SCNT_W'(SEGMENTS)) begin
            count_eff = CNT_W'(SEGMENTS);
        end else begin
            count_eff = CNT_W'(r_seg_count);
        end
    end

    assign emit    = r_busy && (CNT_W'(r_pos) < count_eff);
    assign is_last = (CNT_W'(r_pos) + CNT_W'(1)) == count_eff;
    assign step    = r_busy && (!emit || !r_out_valid || o_out.ready);

    assign i_in.ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_in.valid && !r_busy) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (step) begin
            r_pos <= r_pos + IDX_W'(1);
            if (r_pos == IDX_W'(SEGMENTS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && !r_busy) begin
            r_cur <= i_in.current_segment;
        end
    end

    assign ctrl.cur      = r_cur;
    assign ctrl.idx      = r_pos;
    assign ctrl.max_prio = r_max_prio;
    assign ctrl.rate     = r_rate;

    spwt_update u_update (
        .i_ctrl  (ctrl),
        .i_w     (cell_q[0]),
        .o_w     (new_w)
    );

    assign ring_in = emit ? new_w : cell_q[0];

    for (genvar k = 0; k < SEGMENTS; k++) begin : g_cell
        logic [W_W-1:0] d;
        if (k == SEGMENTS - 1) begin : g_tail
            assign d = ring_in;
        end else begin : g_mid
            assign d = cell_q[k+1];
        end
        spwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (step),
            .i_d     (d),
            .o_q     (cell_q[k])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_idx    <= r_pos;
            r_out_weight <= new_w;
            r_out_wanted <= new_w != '0;
            r_out_last   <= is_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.segment_index = r_out_idx;
    assign o_out.weight        = r_out_weight;
    assign o_out.wanted        = r_out_wanted;
    assign o_out.last          = r_out_last;

endmodule

FILE: rtl/spwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight table port checker
// Watches the top-level channels for ordering and payload consistency.
// ----------------------------------------------------------------------------
module spwt_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [spwt_pkg::W_W-1:0] i_out_weight,
    input logic                     i_out_wanted,
    input logic                     i_out_last
);
    import spwt_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_weight)
            && $stable(i_out_last))
        else $error("result changed while stalled");

    a_wanted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_wanted == (i_out_weight != '0)))
        else $error("wanted flag disagrees with weight");

    // Once an event is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("event taken while a pass was starting");

    // A result that is not the last of its pass means the pass is still running.
    a_no_accept_mid_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready before the last result of a pass");

endmodule

bind segment_prefetch_weight_table spwt_checker u_spwt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_weight (o_out.weight),
    .i_out_wanted (o_out.wanted),
    .i_out_last   (o_out.last)
);

FILE: tb/sv/tb_segment_prefetch_weight_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment prefetch weight table testbench
// Drives segment-change transactions and register writes into the weight
// table, predicts every weight the block emits, and compares each result
// transaction field by field. Directed tests cover the register extremes and
// the segment count corner cases. Random playback sequences then run under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_segment_prefetch_weight_table;
    import spwt_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] segment_index;
        logic [W_W-1:0]   weight;
        logic             wanted;
        logic             last;
    } weight_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    spwt_in_if  seg_in ();
    spwt_out_if wt_out ();

    segment_prefetch_weight_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (seg_in),
        .o_out   (wt_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted copy of the block's state and registers.
    logic [W_W-1:0]    weight_table [SEGMENTS];
    logic [MAXP_W-1:0] cfg_max_prio;
    logic [RATE_W-1:0] cfg_decay;
    logic [SCNT_W-1:0] cfg_seg_count;

    weight_result_t expected_weights_q [$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             play_pos;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Recompute every weight in use for one segment change and queue the results.
    function automatic void apply_segment_event(input logic [IDX_W-1:0] cur);
        int count;
        int cur_i;
        int maxp;
        int rate;
        int w;
        int gain;
        weight_result_t res;
        count = (cfg_seg_count == 0) ? 1 :
                (int'(cfg_seg_count) > SEGMENTS) ? SEGMENTS : int'(cfg_seg_count);
        cur_i = int'(cur);
        maxp  = int'(cfg_max_prio);
        rate  = int'(cfg_decay);
        for (int i = 0; i < count; i++) begin
            w = int'(weight_table[i]);
            if (i == cur_i) begin
                w = maxp;
            end else if (i < cur_i) begin
                w = w - (cur_i - i) * rate;
            end else begin
                gain = maxp - (i - cur_i) * rate;
                if (gain < -maxp) begin
                    gain = -maxp;
                end
                w = w + gain;
            end
            if (w < 0) begin
                w = 0;
            end else if (w > 65535) begin
                w = 65535;
            end
            weight_table[i] = W_W'(w);
        end
        for (int i = 0; i < count; i++) begin
            res.segment_index = IDX_W'(i);
            res.weight        = weight_table[i];
            res.wanted        = (weight_table[i] != '0);
            res.last          = (i + 1 == count);
            expected_weights_q.push_back(res);
        end
    endfunction

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        weight_result_t exp_res;
        if (i_rst_n && wt_out.valid && wt_out.ready) begin
            if (expected_weights_q.size() == 0) begin
                $error("unexpected result: segment_index %0d weight %0d",
                       wt_out.segment_index, wt_out.weight);
                mismatch_count++;
            end else begin
                exp_res = expected_weights_q.pop_front();
                if (wt_out.segment_index !== exp_res.segment_index) begin
                    $error("segment_index: expected %0d, actual %0d",
                           exp_res.segment_index, wt_out.segment_index);
                    mismatch_count++;
                end
                if (wt_out.weight !== exp_res.weight) begin
                    $error("weight: expected %0d, actual %0d", exp_res.weight, wt_out.weight);
                    mismatch_count++;
                end
                if (wt_out.wanted !== exp_res.wanted) begin
                    $error("wanted: expected %0d, actual %0d", exp_res.wanted, wt_out.wanted);
                    mismatch_count++;
                end
                if (wt_out.last !== exp_res.last) begin
                    $error("last: expected %0d, actual %0d", exp_res.last, wt_out.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        wt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_segment_event(input logic [IDX_W-1:0] cur);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        seg_in.valid           = 1'b1;
        seg_in.current_segment = cur;
        do begin
            @(posedge i_clk);
        end while (!seg_in.ready);
        apply_segment_event(cur);
        @(negedge i_clk);
        seg_in.valid           = 1'b0;
        seg_in.current_segment = IDX_W'($urandom());
    endtask

    // Wait until every predicted result has arrived and the ring is back in place.
    task automatic drain_results();
        while (expected_weights_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SEGMENTS + 4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_code, input logic [DATA_W-1:0] value);
        int             fw;
        logic [DATA_W-1:0] data;
        drain_results();
        case (reg_code)
            REG_MAX_PRIO: fw = MAXP_W;
            REG_DECAY:    fw = RATE_W;
            default:      fw = SCNT_W;
        endcase
        // Upper bits beyond the field carry noise; the block keeps only the field.
        data = (DATA_W'($urandom()) << fw) | value;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({reg_code, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (reg_code)
            REG_MAX_PRIO: cfg_max_prio  = data[MAXP_W-1:0];
            REG_DECAY:    cfg_decay     = data[RATE_W-1:0];
            default:      cfg_seg_count = data[SCNT_W-1:0];
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_settings(input int maxp, input int rate, input int count);
        write_register(REG_MAX_PRIO, DATA_W'(maxp));
        write_register(REG_DECAY, DATA_W'(rate));
        write_register(REG_SEG_COUNT, DATA_W'(count));
    endtask

    task automatic test_default_settings();
        send_segment_event(6'd0);
        send_segment_event(6'd5);
        send_segment_event(6'd63);
        send_segment_event(6'd63);
    endtask

    task automatic test_register_extremes();
        write_settings(1023, 0, 64);
        send_segment_event(6'd0);
        send_segment_event(6'd0);
        send_segment_event(6'd32);
        // Steep decay with a tiny forward gain drives most weights to zero.
        write_settings(1, 255, 64);
        send_segment_event(6'd10);
        send_segment_event(6'd63);
        // Zero priority: the current segment ends at zero as well.
        write_settings(0, 7, 64);
        send_segment_event(6'd20);
        send_segment_event(6'd40);
    endtask

    task automatic test_segment_count_cases();
        write_settings(200, 4, 0);
        send_segment_event(6'd0);
        send_segment_event(6'd5);
        write_settings(300, 2, 127);
        send_segment_event(6'd63);
        write_settings(500, 9, 65);
        send_segment_event(6'd1);
        // Current segment outside the playlist: everything in use decays.
        write_settings(800, 1, 10);
        send_segment_event(6'd40);
        send_segment_event(6'd9);
        // Growing the count again brings back the untouched tail.
        write_settings(100, 3, 64);
        send_segment_event(6'd30);
    endtask

    task automatic pick_random_settings();
        int maxp;
        int rate;
        int count;
        case ($urandom_range(7))
            0:       maxp = 1023;
            1:       maxp = 1;
            2:       maxp = 0;
            default: maxp = $urandom_range(1, 1023);
        endcase
        case ($urandom_range(5))
            0:       rate = 0;
            1:       rate = 255;
            2:       rate = $urandom_range(0, 255);
            default: rate = $urandom_range(0, 40);
        endcase
        case ($urandom_range(9))
            0:       count = 64;
            1:       count = 1;
            2:       count = $urandom_range(65, 127);
            3:       count = 0;
            default: count = $urandom_range(2, 64);
        endcase
        write_settings(maxp, rate, count);
    endtask

    // Mostly sequential playback with seeks, repeats and out-of-playlist events.
    task automatic run_playback(input int n_items);
        int count;
        int pick;
        count = (cfg_seg_count == 0) ? 1 :
                (int'(cfg_seg_count) > SEGMENTS) ? SEGMENTS : int'(cfg_seg_count);
        play_pos = $urandom_range(0, count - 1);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                play_pos = (play_pos + 1) % count;
            end else if (pick < 85) begin
                play_pos = $urandom_range(0, count - 1);
            end else if (pick < 95) begin
                play_pos = $urandom_range(0, SEGMENTS - 1);
            end
            send_segment_event(IDX_W'(play_pos));
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int b = 0; b < 7; b++) begin
            pick_random_settings();
            run_playback(10);
        end
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        seg_in.valid           = 1'b0;
        seg_in.current_segment = '0;
        wt_out.ready           = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        mismatch_count         = 0;
        cfg_max_prio           = 10'd10;
        cfg_decay              = 8'd3;
        cfg_seg_count          = 7'd64;
        for (int i = 0; i < SEGMENTS; i++) begin
            weight_table[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_settings();
        test_register_extremes();
        test_segment_count_cases();
        test_random_phase(0, 0);
        test_random_phase(75, 0);
        test_random_phase(0, 75);
        test_random_phase(34, 34);

        drain_results();
        if (mismatch_count == 0 && expected_weights_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/spwt_pkg.sv
rtl/spwt_if.sv
rtl/spwt_cell.sv
rtl/spwt_update.sv
rtl/segment_prefetch_weight_table.sv
rtl/spwt_checker.sv
tb/sv/tb_segment_prefetch_weight_table.sv
